// File: src/bitmap_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap_block_allocator_macros.svh
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Checked on every clock edge, held off while reset is high.
`define BBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BBA_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Sizes, beat types, status codes and control structs of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int WORD_BITS  = 32;          // power of two
   localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

   localparam int IDX_W   = 10;             // index field width on the ports
   localparam int BIT_W   = $clog2(WORD_BITS);
   localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BLK_W   = WADDR_W + BIT_W;

   // result status codes
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_IGNORED = 2'd2;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [IDX_W-1:0] block_index;
   } req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic [1:0]       status;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch request, rewind word pointer
      logic step;         // advance to next bitmap word
      logic alloc_set;    // mark lowest free bit of current word, answer done
      logic alloc_fail;   // answer bitmap full
      logic free_do;      // run the free request
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_is_free;  // request type on the input port
      logic word_has_free;
      logic last_word;
   } dp_stat_type;

endpackage

// File: src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: accepts a request, walks the bitmap words for an allocate,
// issues one step for a free.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bba_pkg::dp_stat_type stat,
   output bba_pkg::ctl_cmd_type cmd
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_FREE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.req_is_free ? S_FREE : S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (stat.word_has_free) begin
               cmd.alloc_set = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.last_word) begin
               cmd.alloc_fail = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_FREE: begin
            cmd.free_do = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap words, word pointer, lowest-zero search, protect register and
// result register.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::req_item_type req_payload,
   input  logic                  csr_wr_en,
   input  logic [bba_pkg::IDX_W-1:0] csr_wr_data,
   input  bba_pkg::ctl_cmd_type  cmd,
   output bba_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output bba_pkg::rsp_item_type rsp_payload
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] bitmap_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] bitmap_in [NUM_WORDS];
   req_item_type         req_ff;
   logic [WADDR_W-1:0]   word_ptr_ff, word_ptr_in;
   logic [IDX_W-1:0]     protect_ff;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic [WORD_BITS-1:0] cur_word;
   logic [BIT_W-1:0]     zero_bit;
   logic [BLK_W-1:0]     free_blk;
   logic [WADDR_W-1:0]   free_word;
   logic [BIT_W-1:0]     free_bit;
   logic                 free_ok;

   assign cur_word = bitmap_ff[word_ptr_ff];

   // lowest clear bit of the current word
   always_comb begin
      zero_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!cur_word[b]) zero_bit = BIT_W'(b);
      end
   end

   assign stat.req_is_free   = (req_payload.req_type == REQ_FREE);
   assign stat.word_has_free = ~&cur_word;
   assign stat.last_word     = (word_ptr_ff == WADDR_W'(NUM_WORDS - 1));

   // free target: guarded by protect limit and block count
   assign free_blk  = BLK_W'(req_ff.block_index);
   assign free_word = WADDR_W'(free_blk >> BIT_W);
   assign free_bit  = free_blk[BIT_W-1:0];
   assign free_ok   = (req_ff.block_index > protect_ff)
                   && (32'(req_ff.block_index) < 32'(NUM_BLOCKS));

   always_comb begin
      bitmap_in   = bitmap_ff;
      word_ptr_in = word_ptr_ff;
      rsp_in      = rsp_ff;
      if (cmd.load) word_ptr_in = '0;
      if (cmd.step) word_ptr_in = word_ptr_ff + WADDR_W'(1);
      if (cmd.alloc_set) begin
         bitmap_in[word_ptr_ff][zero_bit] = 1'b1;
         rsp_in.result_index = IDX_W'({word_ptr_ff, zero_bit});
         rsp_in.status       = STAT_DONE;
      end
      if (cmd.alloc_fail) begin
         rsp_in.result_index = '0;
         rsp_in.status       = STAT_FULL;
      end
      if (cmd.free_do) begin
         rsp_in.result_index = '0;
         if (free_ok) begin
            bitmap_in[free_word][free_bit] = 1'b0;
            rsp_in.status = STAT_DONE;
         end else begin
            rsp_in.status = STAT_IGNORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) bitmap_ff[w] <= '0;
         word_ptr_ff  <= '0;
         protect_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bitmap_ff    <= bitmap_in;
         word_ptr_ff  <= word_ptr_in;
         rsp_valid_ff <= cmd.alloc_set | cmd.alloc_fail | cmd.free_do;
         if (csr_wr_en) protect_ff <= csr_wr_data;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit used/free bitmap over the disk blocks: allocate lowest free
// block, free a named block above the protect limit.
//
//   channel   ports                         handshake
//   -------   ---------------------------   --------------------------------
//   request   start, busy, req_payload      beat taken when start && !busy
//   result    rsp_valid, rsp_payload        one-cycle strobe, never stalled
//   config    csr_wr_en, csr_wr_data        write on csr_wr_en, no wait
//
// An allocate loads, then scans the words in order, one bitmap word per
// cycle through the scan pointer, up to the first with a free bit or the
// last; a free loads, then takes its single step. The result strobe rises
// in the cycle the block drops busy, and a new beat may be taken in that
// same cycle. Reset (synchronous) clears the bitmap, protect limit, state
// and strobe; no clearing pass. The result side has no backpressure.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
   input  logic                      clock,
   input  logic                      reset,
   // request beat
   input  logic                      start,
   output logic                      busy,
   input  bba_pkg::req_item_type     req_payload,
   // result beat
   output logic                      rsp_valid,
   output bba_pkg::rsp_item_type     rsp_payload,
   // protect limit register
   input  logic                      csr_wr_en,
   input  logic [bba_pkg::IDX_W-1:0] csr_wr_data
);
   import bba_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer: idle -> scan words (allocate) or single free step -> idle
   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // bitmap storage, search and result register
   bba_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: src/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input bba_pkg::req_item_type     req_payload,
   input logic                      rsp_valid,
   input bba_pkg::rsp_item_type     rsp_payload,
   input logic                      csr_wr_en,
   input logic [bba_pkg::IDX_W-1:0] csr_wr_data
);
   import bba_pkg::*;

   // a taken beat keeps the block busy for at least the next cycle
   `BBA_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "no busy after accepted beat")
   // one result per beat: strobes never come back to back
   `BBA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   // a result only closes an operation that was in flight
   `BBA_ASSERT(a_rsp_after_busy, rsp_valid |-> ($past(busy) && !busy), "stray result strobe")
   // failed allocation reports index zero
   `BBA_ASSERT(a_full_zero, (rsp_valid && rsp_payload.status == STAT_FULL) |-> (rsp_payload.result_index == '0), "full result with nonzero index")
   // reset leaves the block idle with no result
   `BBA_ASSERT_RST(a_reset_idle, reset |=> (!busy && !rsp_valid), "not idle after reset")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

// File: sim/tb_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Self-checking bench for the first-fit block allocator. A shadow bitmap
// and protect limit predict every result beat. Stimulus runs in this order:
// a directed opening, mixed allocate/free phases under several protect
// limits, and a closing phase with no idle gaps. The protect limit is only
// written while the block is idle.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int LATENCY   = NUM_WORDS + 8;   // worst allocate scan plus margin
   localparam int MAX_CYCLE = 400000;

   typedef enum logic [1:0] {PLAN_BEAT, PLAN_LIMIT, PLAN_DRAIN} plan_kind_type;

   typedef struct {
      plan_kind_type    kind;
      req_item_type     beat;
      logic [IDX_W-1:0] limit;
      bit               quiet;     // no idle burst after this beat
   } plan_step_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_item_type     req_payload = '0;
   logic             rsp_valid;
   rsp_item_type     rsp_payload;
   logic             csr_wr_en   = 1'b0;
   logic [IDX_W-1:0] csr_wr_data = '0;

   bitmap_block_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow allocator: bitmap and protect limit as the block should hold
   // them, updated in acceptance order.
   // ------------------------------------------------------------------
   bit               shadow_used [NUM_BLOCKS];
   logic [IDX_W-1:0] shadow_limit = '0;

   plan_step_type plan_q [$];    // stimulus waiting for the driver
   rsp_item_type  grant_q [$];   // predicted result beats, oldest first

   int beats_planned = 0;
   int results_seen  = 0;
   int err_count     = 0;
   int n_granted     = 0;
   int n_full        = 0;
   int n_freed       = 0;
   int n_ignored     = 0;
   int n_limits      = 0;

   function automatic rsp_item_type predict_grant(req_item_type rq);
      rsp_item_type r;
      bit           found;
      r.result_index = '0;
      r.status       = STAT_DONE;
      found          = 1'b0;
      if (rq.req_type == REQ_ALLOC) begin
         // lowest free block wins; none free means full, nothing changes
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!found && !shadow_used[b]) begin
               shadow_used[b] = 1'b1;
               r.result_index = IDX_W'(b);
               found          = 1'b1;
            end
         end
         if (found) n_granted++;
         else begin
            r.status = STAT_FULL;
            n_full++;
         end
      end else if (rq.block_index <= shadow_limit || int'(rq.block_index) >= NUM_BLOCKS) begin
         // protected or out of range: ignored
         r.status = STAT_IGNORED;
         n_ignored++;
      end else begin
         // clearing an already free block is still a plain done
         shadow_used[rq.block_index] = 1'b0;
         n_freed++;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus plan helpers
   // ------------------------------------------------------------------
   task automatic add_beat(logic kind, int idx, bit quiet);
      plan_step_type s;
      s.kind              = PLAN_BEAT;
      s.beat.req_type     = kind;
      s.beat.block_index  = IDX_W'(idx);
      s.limit             = '0;
      s.quiet             = quiet;
      plan_q.push_back(s);
      beats_planned++;
   endtask

   // wait for every result, let the block settle, then write the limit
   task automatic add_limit(int limit);
      plan_step_type s;
      s.kind  = PLAN_DRAIN;
      s.beat  = '0;
      s.limit = '0;
      s.quiet = 1'b1;
      plan_q.push_back(s);
      s.kind  = PLAN_LIMIT;
      s.limit = IDX_W'(limit);
      plan_q.push_back(s);
   endtask

   // random mix; frees lean toward the low blocks where allocations live
   task automatic add_mix(int count, bit quiet);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55)
            add_beat(REQ_ALLOC, $urandom_range(0, 1023), quiet);
         else if ($urandom_range(0, 9) < 7)
            add_beat(REQ_FREE, $urandom_range(0, 127), quiet);
         else
            add_beat(REQ_FREE, $urandom_range(0, 1023), quiet);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: presents beats from plan_q, holds start until taken, inserts
   // idle bursts, and handles drain pauses and limit writes.
   // ------------------------------------------------------------------
   int gap_left   = 0;
   int settle_cnt = 0;
   bit settling   = 1'b0;
   bit cur_quiet  = 1'b0;

   always @(posedge clock) begin : driver
      plan_step_type nxt;
      logic          took;
      logic          n_start;
      logic          n_wr;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            grant_q.push_back(predict_grant(req_payload));
            // occasional idle burst after a taken beat; the decrement below begins it at once
            if (!cur_quiet && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(2, 11);
         end
         if (settling) begin
            if (grant_q.size() == 0 && !took) begin
               settle_cnt++;
               if (settle_cnt >= LATENCY) settling = 1'b0;
            end else begin
               settle_cnt = 0;
            end
         end
         n_start = start && !took;
         n_wr    = 1'b0;
         if (!n_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!settling && plan_q.size() > 0) begin
               nxt = plan_q.pop_front();
               case (nxt.kind)
                  PLAN_BEAT: begin
                     req_payload <= nxt.beat;
                     n_start     = 1'b1;
                     cur_quiet   = nxt.quiet;
                  end
                  PLAN_LIMIT: begin
                     // block is idle here; the write lands before any new beat
                     csr_wr_data  <= nxt.limit;
                     n_wr         = 1'b1;
                     shadow_limit = nxt.limit;
                     n_limits++;
                  end
                  PLAN_DRAIN: begin
                     settling   = 1'b1;
                     settle_cnt = 0;
                  end
                  default: ;
               endcase
            end
         end
         start     <= n_start;
         csr_wr_en <= n_wr;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed result beat against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (grant_q.size() == 0) begin
            $error("result beat with nothing expected: result_index %0d status %0d",
                   rsp_payload.result_index, rsp_payload.status);
            err_count++;
         end else begin
            want = grant_q.pop_front();
            if (rsp_payload.result_index !== want.result_index) begin
               $error("result_index mismatch: expected %0d, actual %0d",
                      want.result_index, rsp_payload.result_index);
               err_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_payload.status);
               err_count++;
            end
         end
      end
   end

   // hang guard
   int cycle_cnt = 0;
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLE) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus plan, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      // directed opening, protect limit at its reset value 0
      add_beat(REQ_ALLOC, 0, 1'b0);        // -> 0, index field ignored
      add_beat(REQ_ALLOC, 1023, 1'b0);     // -> 1
      add_beat(REQ_ALLOC, 'h155, 1'b0);    // -> 2
      add_beat(REQ_ALLOC, 'h2aa, 1'b0);    // -> 3
      add_beat(REQ_FREE, 0, 1'b0);         // block 0 at the limit: ignored
      add_beat(REQ_FREE, 2, 1'b0);
      add_beat(REQ_ALLOC, 0, 1'b0);        // reuses 2
      add_beat(REQ_FREE, 3, 1'b0);
      add_beat(REQ_FREE, 3, 1'b0);         // already free: still done
      add_beat(REQ_FREE, 1023, 1'b0);      // top block, never used
      add_beat(REQ_FREE, 'h2aa, 1'b0);
      add_limit(1023);                     // everything protected
      add_beat(REQ_FREE, 1, 1'b0);
      add_beat(REQ_FREE, 1023, 1'b0);
      add_beat(REQ_ALLOC, 0, 1'b0);        // -> 3
      add_limit(2);
      add_beat(REQ_FREE, 2, 1'b0);         // at the limit: ignored
      add_beat(REQ_FREE, 3, 1'b0);
      add_beat(REQ_ALLOC, 0, 1'b0);        // -> 3

      // mixed phases over limit extremes and random limits
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: add_limit(0);
            1: add_limit(1023);
            2: add_limit($urandom_range(0, 63));
            default: add_limit($urandom_range(0, 1023));
         endcase
         add_mix(45 + $urandom_range(0, 10), $urandom_range(0, 3) == 0);
      end

      // closing phase: back to reset limit, back-to-back beats only
      add_limit(0);
      add_mix(60, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (results_seen < beats_planned || plan_q.size() != 0);
      repeat (LATENCY) @(posedge clock);

      if (grant_q.size() != 0) begin
         $error("%0d expected result beats never arrived", grant_q.size());
         err_count++;
      end

      $display("Covered %0d request beats: %0d blocks granted, %0d allocates on a full map,",
               beats_planned, n_granted, n_full);
      $display("  %0d frees done, %0d frees ignored, %0d protect limit writes.",
               n_freed, n_ignored, n_limits);
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
